/* hw/rtl/mteu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteu_pkg: shared types and constants of the multi-timer expiry unit
// Slot count, opcode and event codes, and the structs that move along the
// cell chain and from the controller to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mteu_pkg;

  localparam int TimerSlots = 16;
  localparam int SlotW      = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int CntW       = $clog2(TimerSlots + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    EV_CREATED = 2'd0,
    EV_FULL    = 2'd1,
    EV_EXPIRED = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_DECR,
    CMD_FIRE
  } cell_cmd_e;

  typedef enum logic [1:0] {
    PM_SET,
    PM_CLEAR,
    PM_MIN
  } probe_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECR,
    ST_COUNT,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Search token that walks the chain one cell per cycle.
  typedef struct packed {
    logic             live;
    logic             found;
    logic [31:0]      id;
    logic [SlotW-1:0] slot;
  } probe_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_cmd_e        cmd;
    probe_mode_e      mode;
    logic [SlotW-1:0] fire_slot;
    logic [31:0]      new_id;
    logic [31:0]      period;
    logic             rep;
    logic [31:0]      target;
  } bcast_t;

endpackage

`default_nettype wire

/* hw/rtl/mteu_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteu_cell: one timer slot of the chain
// Holds one timer, acts on the passing search token and on broadcast
// commands, and registers the token for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mteu_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mteu_pkg::SlotW-1:0]    cell_idx_i,
  input  mteu_pkg::bcast_t              bcast_i,
  input  mteu_pkg::probe_t              probe_i,
  output mteu_pkg::probe_t              probe_o,
  output logic                          due_o
);

  logic             valid_q, valid_d;
  logic             due_q, due_d;
  logic [31:0]      id_q, id_d;
  logic [31:0]      period_q, period_d;
  logic [31:0]      rem_q, rem_d;
  logic             rep_q, rep_d;
  mteu_pkg::probe_t probe_q, probe_d;

  always_comb begin
    valid_d  = valid_q;
    due_d    = due_q;
    id_d     = id_q;
    period_d = period_q;
    rem_d    = rem_q;
    rep_d    = rep_q;
    probe_d  = probe_i;

    if (probe_i.live) begin
      case (bcast_i.mode)
        mteu_pkg::PM_SET: begin
          // claim the first free slot
          if (!probe_i.found && !valid_q) begin
            valid_d       = 1'b1;
            due_d         = 1'b0;
            id_d          = bcast_i.new_id;
            period_d      = bcast_i.period;
            rem_d         = bcast_i.period;
            rep_d         = bcast_i.rep;
            probe_d.found = 1'b1;
            probe_d.id    = bcast_i.new_id;
            probe_d.slot  = cell_idx_i;
          end
        end
        mteu_pkg::PM_CLEAR: begin
          if (!probe_i.found && valid_q && id_q == bcast_i.target) begin
            valid_d       = 1'b0;
            due_d         = 1'b0;
            probe_d.found = 1'b1;
            probe_d.slot  = cell_idx_i;
          end
        end
        mteu_pkg::PM_MIN: begin
          // strict compare keeps the lower slot on equal ids
          if (due_q && (!probe_i.found || id_q < probe_i.id)) begin
            probe_d.found = 1'b1;
            probe_d.id    = id_q;
            probe_d.slot  = cell_idx_i;
          end
        end
        default: ;
      endcase
    end

    case (bcast_i.cmd)
      mteu_pkg::CMD_DECR: begin
        if (valid_q) begin
          if (rem_q <= 32'd1) begin
            due_d = 1'b1;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
      end
      mteu_pkg::CMD_FIRE: begin
        if (bcast_i.fire_slot == cell_idx_i) begin
          due_d = 1'b0;
          if (rep_q) begin
            rem_d = period_q;
          end else begin
            valid_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      due_q   <= 1'b0;
      probe_q <= '0;
    end else begin
      valid_q <= valid_d;
      due_q   <= due_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    period_q <= period_d;
    rem_q    <= rem_d;
    rep_q    <= rep_d;
  end

  assign probe_o = probe_q;
  assign due_o   = due_q;

endmodule

`default_nettype wire

/* hw/rtl/mteu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteu_ctrl: sequencer of the multi-timer expiry unit
// Takes input transfers, launches searches down the cell chain, counts
// due timers and drives the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module mteu_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         opcode_i,
  input  logic [31:0]                        period_ms_i,
  input  logic                               repeat_flag_i,
  input  logic [31:0]                        target_id_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         event_kind_o,
  output logic [31:0]                        result_id_o,
  output logic                               last_of_run_o,
  output mteu_pkg::bcast_t                   bcast_o,
  output mteu_pkg::probe_t                   probe_launch_o,
  input  mteu_pkg::probe_t                   probe_tail_i,
  input  logic [mteu_pkg::TimerSlots-1:0]    due_i
);

  mteu_pkg::state_e               state_q, state_d;
  mteu_pkg::opcode_e              op_q, op_d;
  logic [31:0]                    period_q, period_d;
  logic                           rep_q, rep_d;
  logic [31:0]                    target_q, target_d;
  logic [31:0]                    next_id_q, next_id_d;
  logic [mteu_pkg::CntW-1:0]      count_q, count_d;
  logic                           hit_found_q, hit_found_d;
  logic [31:0]                    hit_id_q, hit_id_d;
  logic [mteu_pkg::SlotW-1:0]     hit_slot_q, hit_slot_d;
  logic                           out_valid_q, out_valid_d;
  logic [1:0]                     kind_q, kind_d;
  logic [31:0]                    res_id_q, res_id_d;
  logic                           last_q, last_d;
  logic [mteu_pkg::CntW-1:0]      due_cnt;
  logic                           launch;
  logic                           out_free;

  always_comb begin
    due_cnt = '0;
    for (int i = 0; i < mteu_pkg::TimerSlots; i++) begin
      due_cnt = due_cnt + mteu_pkg::CntW'(due_i[i]);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    period_d    = period_q;
    rep_d       = rep_q;
    target_d    = target_q;
    next_id_d   = next_id_q;
    count_d     = count_q;
    hit_found_d = hit_found_q;
    hit_id_d    = hit_id_q;
    hit_slot_d  = hit_slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    res_id_d    = res_id_q;
    last_d      = last_q;
    launch      = 1'b0;
    in_stall_o  = 1'b1;

    bcast_o.cmd       = mteu_pkg::CMD_NONE;
    bcast_o.fire_slot = hit_slot_q;
    bcast_o.new_id    = next_id_q;
    bcast_o.period    = period_q;
    bcast_o.rep       = rep_q;
    bcast_o.target    = target_q;
    unique case (op_q)
      mteu_pkg::OP_SET:   bcast_o.mode = mteu_pkg::PM_SET;
      mteu_pkg::OP_CLEAR: bcast_o.mode = mteu_pkg::PM_CLEAR;
      default:            bcast_o.mode = mteu_pkg::PM_MIN;
    endcase

    unique case (state_q)
      mteu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d     = mteu_pkg::opcode_e'(opcode_i);
          period_d = (period_ms_i == 32'd0) ? 32'd1 : period_ms_i;
          rep_d    = repeat_flag_i;
          target_d = target_id_i;
          unique case (mteu_pkg::opcode_e'(opcode_i))
            mteu_pkg::OP_TICK: state_d = mteu_pkg::ST_DECR;
            mteu_pkg::OP_SET, mteu_pkg::OP_CLEAR: begin
              state_d = mteu_pkg::ST_LAUNCH;
            end
            default: ;
          endcase
        end
      end
      mteu_pkg::ST_DECR: begin
        // age every live timer, flag those that fall due
        bcast_o.cmd = mteu_pkg::CMD_DECR;
        state_d     = mteu_pkg::ST_COUNT;
      end
      mteu_pkg::ST_COUNT: begin
        count_d = due_cnt;
        if (due_cnt == '0) begin
          state_d = mteu_pkg::ST_IDLE;
        end else begin
          launch  = 1'b1;
          state_d = mteu_pkg::ST_WAIT;
        end
      end
      mteu_pkg::ST_LAUNCH: begin
        // operands and cell flags are registered by now
        launch  = 1'b1;
        state_d = mteu_pkg::ST_WAIT;
      end
      mteu_pkg::ST_WAIT: begin
        if (probe_tail_i.live) begin
          hit_found_d = probe_tail_i.found;
          hit_id_d    = probe_tail_i.id;
          hit_slot_d  = probe_tail_i.slot;
          state_d     = (op_q == mteu_pkg::OP_CLEAR) ? mteu_pkg::ST_IDLE
                                                     : mteu_pkg::ST_EMIT;
        end
      end
      mteu_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (op_q == mteu_pkg::OP_SET) begin
            kind_d   = hit_found_q ? mteu_pkg::EV_CREATED : mteu_pkg::EV_FULL;
            res_id_d = hit_found_q ? hit_id_q : 32'd0;
            last_d   = 1'b1;
            if (hit_found_q) begin
              next_id_d = next_id_q + 32'd1;
            end
            state_d = mteu_pkg::ST_IDLE;
          end else begin
            bcast_o.cmd = mteu_pkg::CMD_FIRE;
            kind_d      = mteu_pkg::EV_EXPIRED;
            res_id_d    = hit_id_q;
            last_d      = (count_q == mteu_pkg::CntW'(1));
            count_d     = count_q - mteu_pkg::CntW'(1);
            if (count_q == mteu_pkg::CntW'(1)) begin
              state_d = mteu_pkg::ST_IDLE;
            end else begin
              state_d = mteu_pkg::ST_LAUNCH;
            end
          end
        end
      end
      default: state_d = mteu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mteu_pkg::ST_IDLE;
      op_q        <= mteu_pkg::OP_TICK;
      next_id_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      next_id_q   <= next_id_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    rep_q       <= rep_d;
    target_q    <= target_d;
    hit_found_q <= hit_found_d;
    hit_id_q    <= hit_id_d;
    hit_slot_q  <= hit_slot_d;
    kind_q      <= kind_d;
    res_id_q    <= res_id_d;
    last_q      <= last_d;
  end

  assign probe_launch_o.live  = launch;
  assign probe_launch_o.found = 1'b0;
  assign probe_launch_o.id    = '0;
  assign probe_launch_o.slot  = '0;

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign result_id_o   = res_id_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

/* hw/rtl/multi_timer_expiry_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_expiry_unit: table of millisecond software timers
// A row of timer cells with a sequencer that sets, clears and ages timers
// and reports every expiry in ascending id order.
// ----------------------------------------------------------------------------
`default_nettype none

// One item is processed at a time; the input stalls until it is done. A set
// or clear launches a search token in the cycle after its transfer and the
// token walks the chain of TimerSlots cells, one cell per cycle. A set and
// each expiry also wait while the result port is stalled. A tick first ages
// every timer and then counts those due, and each expiry needs one full
// minimum-id pass of the token through the chain. Timers due on the same
// tick are reported lowest id first (lower slot first on equal ids), the
// last one carrying last_of_run_o. A set that finds no free slot reports a
// full table with id 0. Clear and a tick with nothing due give no result.

module multi_timer_expiry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] period_ms_i,
  input  logic        repeat_flag_i,
  input  logic [31:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [31:0] result_id_o,
  output logic        last_of_run_o
);

  mteu_pkg::bcast_t                 bcast;
  mteu_pkg::probe_t                 probe [mteu_pkg::TimerSlots+1];
  logic [mteu_pkg::TimerSlots-1:0]  due;

  // Sequencer: owns the id counter, the due count and the result register.
  mteu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .period_ms_i    (period_ms_i),
    .repeat_flag_i  (repeat_flag_i),
    .target_id_i    (target_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .result_id_o    (result_id_o),
    .last_of_run_o  (last_of_run_o),
    .bcast_o        (bcast),
    .probe_launch_o (probe[0]),
    .probe_tail_i   (probe[mteu_pkg::TimerSlots]),
    .due_i          (due)
  );

  // Chain of slots: the token enters at slot 0 and leaves after the last.
  for (genvar g = 0; g < mteu_pkg::TimerSlots; g++) begin : g_cell
    mteu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (mteu_pkg::SlotW'(g)),
      .bcast_i    (bcast),
      .probe_i    (probe[g]),
      .probe_o    (probe[g+1]),
      .due_o      (due[g])
    );
  end

endmodule

`default_nettype wire
